// ===== hdl/ricrc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and CRC helper functions for the RoCEv2 ICRC engine.
// Depends on nothing; every other file refers to it by scoped names.
package ricrc_pkg;

   localparam int CRC_WIDTH     = 32;
   localparam int HEADER_SKIP   = 14;
   localparam int TRAILER_BYTES = 4;

   localparam int BYTE_W      = 8;
   localparam int ICRC_W      = 32;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_INDEX_W = 3;

   // frame byte counter, saturating
   localparam int POS_W = 6;
   localparam logic [POS_W-1:0] POS_MAX = POS_W'((1 << POS_W) - 1);
   localparam logic [POS_W-1:0] MIN_FRAME = POS_W'(HEADER_SKIP + TRAILER_BYTES);
   localparam logic [POS_W-1:0] TRAILER_POS = POS_W'(TRAILER_BYTES);

   // pseudo-LRH bytes fed before each frame
   localparam int PRELOAD_BYTES = 8;
   localparam int PRELOAD_CNT_W = $clog2(PRELOAD_BYTES + 1);
   localparam logic [BYTE_W-1:0] FILL_BYTE = 8'hFF;

   // frame offsets that are replaced by all ones
   localparam int MASK_COUNT = 7;
   localparam logic [POS_W-1:0] MASK_OFFSETS [MASK_COUNT] = '{
      6'd15, 6'd22, 6'd24, 6'd25, 6'd40, 6'd41, 6'd46
   };

   typedef logic [CRC_WIDTH-1:0] crc_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_POLY        = 3'd0,
      CSR_INIT_VALUE  = 3'd1,
      CSR_FINAL_XOR   = 3'd2,
      CSR_REFLECT_IN  = 3'd3,
      CSR_REFLECT_OUT = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [CSR_DATA_W-1:0] poly;
      logic [CSR_DATA_W-1:0] init_value;
      logic [CSR_DATA_W-1:0] final_xor;
      logic                  reflect_in;
      logic                  reflect_out;
   } cfg_type;

   typedef struct packed {
      crc_type value;
      logic    busy;
   } preload_type;

   function automatic logic [BYTE_W-1:0] reverse_byte(input logic [BYTE_W-1:0] data);
      logic [BYTE_W-1:0] r;
      r = '0;
      for (int i = 0; i < BYTE_W; i++) begin
         r[i] = data[BYTE_W-1-i];
      end
      return r;
   endfunction

   function automatic crc_type reverse_crc(input crc_type data);
      crc_type r;
      r = '0;
      for (int i = 0; i < CRC_WIDTH; i++) begin
         r[i] = data[CRC_WIDTH-1-i];
      end
      return r;
   endfunction

   // one byte through the MSB-first shift register, eight XOR steps
   function automatic crc_type crc_feed(input crc_type crc_in,
                                        input logic [BYTE_W-1:0] data,
                                        input crc_type poly,
                                        input logic reflect);
      logic [BYTE_W-1:0] b;
      crc_type r;
      b = reflect ? reverse_byte(data) : data;
      r = crc_in ^ (crc_type'(b) << (CRC_WIDTH - BYTE_W));
      for (int i = 0; i < BYTE_W; i++) begin
         r = r[CRC_WIDTH-1] ? ((r << 1) ^ poly) : (r << 1);
      end
      return r;
   endfunction

   function automatic logic is_masked_offset(input logic [POS_W-1:0] pos);
      logic hit;
      hit = 1'b0;
      for (int i = 0; i < MASK_COUNT; i++) begin
         hit = hit | (pos == MASK_OFFSETS[i]);
      end
      return hit;
   endfunction

endpackage

// ===== hdl/ricrc_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for frame bytes in and ICRC results out.
// Depends on ricrc_pkg for field widths.
interface ricrc_req_if;
   logic                          valid;
   logic                          ready;
   logic [ricrc_pkg::BYTE_W-1:0]  frame_byte;
   logic                          last_byte;

   modport source (output valid, output frame_byte, output last_byte, input ready);
   modport sink   (input valid, input frame_byte, input last_byte, output ready);
endinterface

interface ricrc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ricrc_pkg::ICRC_W-1:0]  icrc;
   logic                          short_frame;

   modport source (output valid, output icrc, output short_frame, input ready);
   modport sink   (input valid, input icrc, input short_frame, output ready);
endinterface

// ===== hdl/ricrc_csr.sv =====
`timescale 1ns / 1ps
// Configuration register file: polynomial, init value, final XOR, reflection.
// Depends on ricrc_pkg.
module ricrc_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [ricrc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [ricrc_pkg::CSR_DATA_W-1:0]   csr_wr_data,
   output ricrc_pkg::cfg_type                 cfg
);

   ricrc_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.poly        <= 32'h04C1_1DB7;
         cfg_ff.init_value  <= 32'hFFFF_FFFF;
         cfg_ff.final_xor   <= 32'hFFFF_FFFF;
         cfg_ff.reflect_in  <= 1'b1;
         cfg_ff.reflect_out <= 1'b1;
      end else if (csr_wr_en) begin
         unique case (ricrc_pkg::csr_index_type'(csr_index))
            ricrc_pkg::CSR_POLY:        cfg_ff.poly        <= csr_wr_data;
            ricrc_pkg::CSR_INIT_VALUE:  cfg_ff.init_value  <= csr_wr_data;
            ricrc_pkg::CSR_FINAL_XOR:   cfg_ff.final_xor   <= csr_wr_data;
            ricrc_pkg::CSR_REFLECT_IN:  cfg_ff.reflect_in  <= csr_wr_data[0];
            ricrc_pkg::CSR_REFLECT_OUT: cfg_ff.reflect_out <= csr_wr_data[0];
            default: ;  // drop writes past the register list
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hdl/ricrc_preload.sv =====
`timescale 1ns / 1ps
// Computes the CRC state after the eight all-ones pseudo-LRH bytes, one byte
// per cycle, rerun after reset and after every configuration write. Uses ricrc_pkg.
module ricrc_preload (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    restart,
   input  ricrc_pkg::cfg_type      cfg,
   output ricrc_pkg::preload_type  preload
);

   localparam logic [ricrc_pkg::PRELOAD_CNT_W-1:0] CNT_DONE =
      ricrc_pkg::PRELOAD_CNT_W'(ricrc_pkg::PRELOAD_BYTES);

   logic                                   pending_ff;
   logic [ricrc_pkg::PRELOAD_CNT_W-1:0]    cnt_ff;
   ricrc_pkg::crc_type                     crc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 1'b1;
         cnt_ff     <= '0;
      end else if (restart) begin
         pending_ff <= 1'b1;
         cnt_ff     <= '0;
      end else if (pending_ff) begin
         // load from the settled registers, then start feeding
         pending_ff <= 1'b0;
         cnt_ff     <= '0;
      end else if (cnt_ff != CNT_DONE) begin
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (pending_ff) begin
         crc_ff <= cfg.init_value[ricrc_pkg::CRC_WIDTH-1:0];
      end else if (cnt_ff != CNT_DONE) begin
         crc_ff <= ricrc_pkg::crc_feed(crc_ff, ricrc_pkg::FILL_BYTE,
                                       cfg.poly[ricrc_pkg::CRC_WIDTH-1:0],
                                       cfg.reflect_in);
      end
   end

   assign preload.value = crc_ff;
   assign preload.busy  = pending_ff | restart | (cnt_ff != CNT_DONE);

endmodule

// ===== hdl/ricrc_datapath.sv =====
`timescale 1ns / 1ps
// Input register, byte counter, trailer delay line, CRC register and result
// register. Uses ricrc_pkg and the channel interfaces in ricrc_if.sv.
module ricrc_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  ricrc_pkg::cfg_type      cfg,
   input  ricrc_pkg::preload_type  preload,
   ricrc_req_if.sink               req_bus,
   ricrc_rsp_if.source             rsp_bus
);

   localparam int TB = ricrc_pkg::TRAILER_BYTES;

   logic                              s1_valid_ff;
   logic [ricrc_pkg::BYTE_W-1:0]      s1_byte_ff;
   logic                              s1_last_ff;

   logic [ricrc_pkg::POS_W-1:0]       pos_ff;
   ricrc_pkg::crc_type                crc_ff;
   logic [ricrc_pkg::BYTE_W-1:0]      delay_ff [TB];

   logic                              rsp_valid_ff;
   logic [ricrc_pkg::ICRC_W-1:0]      rsp_icrc_ff;
   logic                              rsp_short_ff;

   logic                              req_xfer;
   logic                              s1_go;
   ricrc_pkg::crc_type                poly;
   ricrc_pkg::crc_type                crc_base;
   ricrc_pkg::crc_type                crc_in;
   ricrc_pkg::crc_type                crc_out;
   logic                              feed_en;
   logic [ricrc_pkg::POS_W-1:0]       leaving;
   logic [ricrc_pkg::BYTE_W-1:0]      out_byte;
   logic [ricrc_pkg::POS_W-1:0]       pos_inc;

   assign poly = cfg.poly[ricrc_pkg::CRC_WIDTH-1:0];

   // a byte without last never waits; a last byte waits for the result slot
   assign s1_go = s1_valid_ff & (~s1_last_ff | ~rsp_valid_ff | rsp_bus.ready);
   assign req_bus.ready = ~preload.busy & (~s1_valid_ff | s1_go);
   assign req_xfer = req_bus.valid & req_bus.ready;

   always_comb begin
      crc_base = (pos_ff == '0) ? preload.value : crc_ff;
      leaving  = pos_ff - ricrc_pkg::TRAILER_POS;
      feed_en  = (pos_ff >= ricrc_pkg::MIN_FRAME);
      out_byte = ricrc_pkg::is_masked_offset(leaving) ? ricrc_pkg::FILL_BYTE
                                                      : delay_ff[TB-1];
      crc_in   = feed_en ? ricrc_pkg::crc_feed(crc_base, out_byte, poly, cfg.reflect_in)
                         : crc_base;
      pos_inc  = (pos_ff == ricrc_pkg::POS_MAX) ? pos_ff : pos_ff + 1'b1;
      crc_out  = (cfg.reflect_out ? ricrc_pkg::reverse_crc(crc_in) : crc_in)
                 ^ cfg.final_xor[ricrc_pkg::CRC_WIDTH-1:0];
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_xfer) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_go) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_go) begin
            pos_ff <= s1_last_ff ? '0 : pos_inc;
         end
         rsp_valid_ff <= (rsp_valid_ff & ~rsp_bus.ready) | (s1_go & s1_last_ff);
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_byte_ff <= req_bus.frame_byte;
         s1_last_ff <= req_bus.last_byte;
      end
      if (s1_go) begin
         crc_ff      <= crc_in;
         delay_ff[0] <= s1_byte_ff;
         for (int k = 1; k < TB; k++) begin
            delay_ff[k] <= delay_ff[k-1];
         end
         if (s1_last_ff) begin
            rsp_icrc_ff  <= ricrc_pkg::ICRC_W'(crc_out);
            rsp_short_ff <= (pos_inc < ricrc_pkg::MIN_FRAME);
         end
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.icrc        = rsp_icrc_ff;
   assign rsp_bus.short_frame = rsp_short_ff;

endmodule

// ===== hdl/rocev2_icrc_engine_core.sv =====
`timescale 1ns / 1ps
// Top level of the RoCEv2 invariant CRC engine.
// Depends on ricrc_pkg, ricrc_if.sv, ricrc_csr, ricrc_preload and ricrc_datapath.
//
//   channel   dir   handshake         payload
//   req_bus   in    valid / ready     frame_byte[7:0], last_byte
//   rsp_bus   out   valid / ready     icrc[31:0], short_frame
//   csr_*     in    csr_wr_en         csr_index[2:0], csr_wr_data[31:0]
//
// One frame byte per cycle while req_bus.ready is high; an accepted last byte goes
// through the input register, then its result into the result register. The byte
// update is one eight-step XOR network. req_bus.ready stays low after reset, and
// from the cycle of a register write, while the pseudo-LRH preload is rebuilt
// one byte per cycle.
// A result waiting in the output register stalls only a following last byte.
module rocev2_icrc_engine_core (
   input  logic                               clock,
   input  logic                               reset,
   ricrc_req_if.sink                          req_bus,
   ricrc_rsp_if.source                        rsp_bus,
   input  logic                               csr_wr_en,
   input  logic [ricrc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [ricrc_pkg::CSR_DATA_W-1:0]   csr_wr_data
);

   ricrc_pkg::cfg_type      cfg;
   ricrc_pkg::preload_type  preload;

   ricrc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cfg         (cfg)
   );

   ricrc_preload u_preload (
      .clock   (clock),
      .reset   (reset),
      .restart (csr_wr_en),
      .cfg     (cfg),
      .preload (preload)
   );

   ricrc_datapath u_datapath (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .preload (preload),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

endmodule

// ===== tb/tb_rocev2_icrc_engine_core.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for rocev2_icrc_engine_core: frames of random length, content and
// configuration are checked against a byte-level ICRC predictor kept inside this file.
// Depends on ricrc_pkg, ricrc_if.sv and the engine RTL.
module tb_rocev2_icrc_engine_core;

   typedef struct packed {
      logic [31:0] icrc;
      logic        short_frame;
   } icrc_result_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [ricrc_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [ricrc_pkg::CSR_DATA_W-1:0] csr_wr_data;

   ricrc_req_if req_bus();
   ricrc_rsp_if rsp_bus();

   rocev2_icrc_engine_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // predictor state
   logic [31:0] cfg_poly;
   logic [31:0] cfg_init;
   logic [31:0] cfg_xor;
   logic cfg_refl_in;
   logic cfg_refl_out;
   logic [31:0] icrc_acc;
   int frame_pos;
   logic [7:0] trailer_line [ricrc_pkg::TRAILER_BYTES];

   icrc_result_type pending_icrc[$];
   int unsigned mismatches;
   int unsigned bytes_sent;
   int unsigned hold_request;
   bit steady;

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   initial begin
      #2000000;
      $display("Simulation FAILED");
      $finish;
   end

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (steady || r < 60) begin
         return 0;
      end else if (r < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(4, 24);
   endfunction

   function automatic logic [31:0] icrc_shift_byte(input logic [31:0] acc,
                                                   input logic [7:0] data);
      logic [7:0] d;
      d = data;
      if (cfg_refl_in) begin
         for (int i = 0; i < 8; i++) d[i] = data[7-i];
      end
      acc = acc ^ {d, 24'h0};
      for (int i = 0; i < 8; i++) begin
         acc = acc[31] ? ((acc << 1) ^ cfg_poly) : (acc << 1);
      end
      return acc;
   endfunction

   // register state after the eight all-ones pseudo-LRH bytes
   function automatic logic [31:0] lrh_seed();
      logic [31:0] acc;
      acc = cfg_init;
      for (int i = 0; i < 8; i++) acc = icrc_shift_byte(acc, 8'hFF);
      return acc;
   endfunction

   function automatic bit invariant_field(input int pos);
      case (pos)
         15, 22, 24, 25, 40, 41, 46: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   function automatic void predict_byte(input logic [7:0] data, input logic last);
      logic [7:0] oldest;
      logic [31:0] folded;
      icrc_result_type res;
      if (frame_pos == 0) begin
         icrc_acc = lrh_seed();
      end
      // a byte reaches the CRC only once the trailer bytes have passed it
      if (frame_pos >= ricrc_pkg::TRAILER_BYTES) begin
         oldest = trailer_line[ricrc_pkg::TRAILER_BYTES-1];
         if (frame_pos - ricrc_pkg::TRAILER_BYTES >= ricrc_pkg::HEADER_SKIP) begin
            if (invariant_field(frame_pos - ricrc_pkg::TRAILER_BYTES)) oldest = 8'hFF;
            icrc_acc = icrc_shift_byte(icrc_acc, oldest);
         end
      end
      for (int k = ricrc_pkg::TRAILER_BYTES - 1; k > 0; k--) begin
         trailer_line[k] = trailer_line[k-1];
      end
      trailer_line[0] = data;
      if (frame_pos < 63) frame_pos++;
      if (last) begin
         folded = icrc_acc;
         if (cfg_refl_out) begin
            for (int i = 0; i < 32; i++) folded[i] = icrc_acc[31-i];
         end
         res.icrc = folded ^ cfg_xor;
         res.short_frame = (frame_pos < ricrc_pkg::HEADER_SKIP + ricrc_pkg::TRAILER_BYTES);
         pending_icrc.push_back(res);
         frame_pos = 0;
      end
   endfunction

   // result side: random stalls, plus long hold-offs on request
   initial begin : rsp_ready_driver
      int unsigned stall_left;
      int unsigned hold_left;
      stall_left = 0;
      hold_left = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (hold_left != 0) begin
            rsp_bus.ready = 1'b0;
            hold_left--;
         end else if (stall_left != 0 && !steady) begin
            rsp_bus.ready = 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready = 1'b1;
            stall_left = pick_gap();
         end
      end
   end

   always @(posedge clock) begin : icrc_checker
      icrc_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_icrc.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("ERROR: unexpected result icrc=%h short_frame=%b",
                        rsp_bus.icrc, rsp_bus.short_frame);
            end
         end else begin
            want = pending_icrc.pop_front();
            if (rsp_bus.icrc !== want.icrc) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("ERROR: icrc expected %h got %h", want.icrc, rsp_bus.icrc);
               end
            end
            if (rsp_bus.short_frame !== want.short_frame) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("ERROR: short_frame expected %b got %b",
                           want.short_frame, rsp_bus.short_frame);
               end
            end
         end
      end
   end

   task automatic push_byte(input logic [7:0] data, input logic last);
      int unsigned gap;
      @(negedge clock);
      req_bus.valid = 1'b1;
      req_bus.frame_byte = data;
      req_bus.last_byte = last;
      do @(posedge clock); while (!req_bus.ready);
      predict_byte(data, last);
      bytes_sent++;
      gap = pick_gap();
      if (gap != 0) begin
         @(negedge clock);
         req_bus.valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic send_frame(input int len);
      int unsigned fill;
      logic [7:0] data;
      fill = $urandom_range(0, 9);
      for (int i = 0; i < len; i++) begin
         case (fill)
            0: data = 8'h00;
            1: data = 8'hFF;
            default: data = 8'($urandom_range(0, 255));
         endcase
         push_byte(data, i == len - 1);
      end
   endtask

   function automatic int pick_length();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 15) return int'($urandom_range(1, 17));
      if (r < 85) return int'($urandom_range(18, 64));
      return int'($urandom_range(65, 120));
   endfunction

   // hold off the sender until every predicted result has been seen
   task automatic wait_drained();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (pending_icrc.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input ricrc_pkg::csr_index_type idx, input logic [31:0] data);
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wr_data = data;
      @(negedge clock);
      csr_wr_en = 1'b0;
      case (idx)
         ricrc_pkg::CSR_POLY:        cfg_poly = data;
         ricrc_pkg::CSR_INIT_VALUE:  cfg_init = data;
         ricrc_pkg::CSR_FINAL_XOR:   cfg_xor = data;
         ricrc_pkg::CSR_REFLECT_IN:  cfg_refl_in = data[0];
         ricrc_pkg::CSR_REFLECT_OUT: cfg_refl_out = data[0];
         default: ;
      endcase
   endtask

   task automatic apply_config(input logic [31:0] poly, input logic [31:0] init,
                               input logic [31:0] fxor, input logic rin, input logic rout);
      wait_drained();
      write_csr(ricrc_pkg::CSR_POLY, poly);
      write_csr(ricrc_pkg::CSR_INIT_VALUE, init);
      write_csr(ricrc_pkg::CSR_FINAL_XOR, fxor);
      write_csr(ricrc_pkg::CSR_REFLECT_IN, {31'h0, rin});
      write_csr(ricrc_pkg::CSR_REFLECT_OUT, {31'h0, rout});
   endtask

   // one-byte frame, all-ones frame within the trailer, minimum full-length frame
   task automatic test_directed();
      push_byte(8'h00, 1'b1);
      for (int i = 0; i < 4; i++) push_byte(8'hFF, i == 3);
      for (int i = 0; i < 18; i++) push_byte(8'($urandom_range(0, 255)), i == 17);
   endtask

   task automatic test_random_frames(input int unsigned target);
      while (bytes_sent < target) send_frame(pick_length());
   endtask

   task automatic test_config_sweep();
      logic [31:0] r0;
      logic [31:0] r1;
      logic [31:0] r2;
      apply_config(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0);
      send_frame(pick_length());
      apply_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b1);
      send_frame(pick_length());
      apply_config(32'h1EDC_6F41, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b1);
      send_frame(pick_length());
      apply_config(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b0);
      send_frame(pick_length());
      for (int n = 0; n < 3; n++) begin
         r0 = $urandom;
         r1 = $urandom;
         r2 = $urandom;
         apply_config(r0, r1, r2, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         send_frame(pick_length());
      end
      apply_config(32'h04C1_1DB7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1);
   endtask

   // short frames against a stalled result port: the second last byte must stall
   task automatic test_result_backpressure();
      wait_drained();
      hold_request = 400;
      repeat (30) send_frame(int'($urandom_range(1, 5)));
      wait_drained();
   endtask

   task automatic test_back_to_back();
      steady = 1'b1;
      repeat (4) send_frame(int'($urandom_range(1, 40)));
      steady = 1'b0;
   endtask

   initial begin
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wr_data = '0;
      req_bus.valid = 1'b0;
      req_bus.frame_byte = '0;
      req_bus.last_byte = 1'b0;
      mismatches = 0;
      bytes_sent = 0;
      hold_request = 0;
      steady = 1'b0;
      cfg_poly = 32'h04C1_1DB7;
      cfg_init = 32'hFFFF_FFFF;
      cfg_xor = 32'hFFFF_FFFF;
      cfg_refl_in = 1'b1;
      cfg_refl_out = 1'b1;
      frame_pos = 0;
      icrc_acc = '0;
      for (int k = 0; k < ricrc_pkg::TRAILER_BYTES; k++) trailer_line[k] = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_random_frames(150);
      test_config_sweep();
      test_result_backpressure();
      test_back_to_back();
      test_random_frames(700);

      wait_drained();
      repeat (20) @(posedge clock);
      if (mismatches == 0 && pending_icrc.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
